// File: design/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// shared types and constants of the shell line tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

    // character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // configuration port
    localparam int          ADDR_W         = 3;
    localparam int          DATA_W         = 32;
    localparam logic        REG_MAX_TOKENS = 1'b0;   // word index of max_tokens
    localparam logic [7:0]  MAX_TOKENS_RST = 8'd16;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_DOUBLE = 2'd1,
        QM_SINGLE = 2'd2
    } t_quote;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNTERM  = 2'd1,
        ST_TOOMANY = 2'd2
    } t_status;

    typedef struct packed {
        t_quote      quote;
        logic        esc;
        logic        in_tok;
        logic [7:0]  cnt;
        t_status     err;
    } t_state;

    localparam t_state STATE_RST = '{quote: QM_NONE, esc: 1'b0, in_tok: 1'b0,
                                     cnt: 8'd0, err: ST_OK};

    typedef struct packed {
        logic        char_valid;
        logic [7:0]  out_char;
        logic        token_end;
        logic        line_end;
        t_status     line_status;
        logic [7:0]  token_total;
    } t_result;

endpackage

`default_nettype wire

// File: design/slt_step.sv
// ----------------------------------------------------------------------------
// slt_step
// next-state and result logic for one byte or end of line of the command line
// ----------------------------------------------------------------------------
`default_nettype none

module slt_step (
    input  wire slt_pkg::t_state  i_state,
    input  wire logic [7:0]       i_max_tokens,
    input  wire logic             i_has_byte,
    input  wire logic [7:0]       i_in_byte,
    input  wire logic             i_end_of_line,
    output slt_pkg::t_state       o_state,
    output slt_pkg::t_result      o_result
);

    always_comb begin
        slt_pkg::t_state st;
        logic            cv;
        logic [7:0]      ch;
        logic            te;
        logic            fin;

        st  = i_state;
        cv  = 1'b0;
        ch  = 8'd0;
        te  = 1'b0;
        fin = 1'b0;

        // byte handling
        if (i_has_byte && i_state.err == slt_pkg::ST_OK) begin
            case (i_state.quote)
                slt_pkg::QM_DOUBLE: begin
                    if (i_state.esc) begin
                        st.esc = 1'b0;
                        cv     = 1'b1;
                        ch     = i_in_byte;
                    end else if (i_in_byte == slt_pkg::CH_DQUOTE) begin
                        st.quote = slt_pkg::QM_NONE;
                    end else if (i_in_byte == slt_pkg::CH_BSLASH) begin
                        st.esc = 1'b1;
                    end else begin
                        cv = 1'b1;
                        ch = i_in_byte;
                    end
                end
                slt_pkg::QM_SINGLE: begin
                    if (i_in_byte == slt_pkg::CH_SQUOTE) begin
                        st.quote = slt_pkg::QM_NONE;
                    end else begin
                        cv = 1'b1;
                        ch = i_in_byte;
                    end
                end
                default: begin
                    if (i_state.esc) begin
                        st.esc = 1'b0;
                        cv     = 1'b1;
                        ch     = i_in_byte;
                    end else if (i_in_byte == slt_pkg::CH_SPACE ||
                                 i_in_byte == slt_pkg::CH_TAB) begin
                        fin = i_state.in_tok;
                    end else if (i_in_byte == slt_pkg::CH_DQUOTE) begin
                        st.quote  = slt_pkg::QM_DOUBLE;
                        st.in_tok = 1'b1;
                    end else if (i_in_byte == slt_pkg::CH_SQUOTE) begin
                        st.quote  = slt_pkg::QM_SINGLE;
                        st.in_tok = 1'b1;
                    end else if (i_in_byte == slt_pkg::CH_BSLASH) begin
                        st.esc    = 1'b1;
                        st.in_tok = 1'b1;
                    end else begin
                        cv        = 1'b1;
                        ch        = i_in_byte;
                        st.in_tok = 1'b1;
                    end
                end
            endcase
        end

        // token closing by a space or tab; clears in_tok, so the end-of-line closing below cannot close it twice
        if (fin) begin
            st.in_tok = 1'b0;
            if (st.cnt >= i_max_tokens) begin
                st.err = slt_pkg::ST_TOOMANY;
            end else begin
                st.cnt = st.cnt + 8'd1;
                te     = 1'b1;
            end
        end

        // end of line closing
        if (i_end_of_line && st.err == slt_pkg::ST_OK) begin
            fin = 1'b0;
            if (st.esc && st.quote == slt_pkg::QM_DOUBLE) begin
                st.err = slt_pkg::ST_UNTERM;
            end else if (st.esc) begin
                st.esc = 1'b0;
                cv     = 1'b1;
                ch     = slt_pkg::CH_BSLASH;
                fin    = 1'b1;
            end else if (st.quote == slt_pkg::QM_DOUBLE ||
                         st.quote == slt_pkg::QM_SINGLE) begin
                st.err = slt_pkg::ST_UNTERM;
            end else begin
                fin = st.in_tok;
            end
            if (fin) begin
                st.in_tok = 1'b0;
                if (st.cnt >= i_max_tokens) begin
                    st.err = slt_pkg::ST_TOOMANY;
                end else begin
                    st.cnt = st.cnt + 8'd1;
                    te     = 1'b1;
                end
            end
        end

        // any error blanks the character and token outputs
        if (i_state.err != slt_pkg::ST_OK || st.err != slt_pkg::ST_OK) begin
            cv = 1'b0;
            ch = 8'd0;
            te = 1'b0;
        end

        o_result.char_valid  = cv;
        o_result.out_char    = ch;
        o_result.token_end   = te;
        o_result.line_end    = i_end_of_line;
        o_result.line_status = i_end_of_line ? st.err : slt_pkg::ST_OK;
        o_result.token_total = st.cnt;

        o_state = i_end_of_line ? slt_pkg::STATE_RST : st;
    end

endmodule

`default_nettype wire

// File: design/shell_line_tokenizer.sv
// ----------------------------------------------------------------------------
// shell_line_tokenizer
// splits a command line into shell-style tokens, one byte per transaction
// ----------------------------------------------------------------------------
// usage
//   input stream: one transaction per byte; tdata carries the byte, tuser is
//   has_byte (low for an empty end-of-line transaction), tlast ends the line
//   output stream: exactly one transaction per input transaction, carrying an
//   optional token character (tuser[0]), a token-end mark (tuser[1]), and on
//   tlast the line status and token count
//   apb port: one register, max_tokens, at byte address 0 (reset 16)
// timing
//   a transaction goes through the input register, then the result register
//   throughput one transaction per cycle while the receiver keeps up; the
//   tokenizer state is updated in the single step between the two registers
// reset and stall
//   synchronous reset empties both stages, clears the per-line state and
//   loads max_tokens with 16
//   when the receiver stalls, the result register holds and the input
//   register fills; tready drops only once both are occupied
// ----------------------------------------------------------------------------
`default_nettype none

module shell_line_tokenizer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input stream
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [slt_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] in_byte
    input  wire logic [slt_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,  // [0] has_byte
    input  wire logic                           i_s_axis_tlast,  // end_of_line
    // output stream
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // [7:0] out_char, [9:8] line_status, [17:10] token_total, [23:18] zero
    output logic [slt_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    // [0] char_valid, [1] token_end
    output logic [slt_pkg::M_TUSER_W-1:0]       o_m_axis_tuser,
    output logic                                o_m_axis_tlast,  // line_end
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [slt_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [slt_pkg::DATA_W-1:0]     pwdata,
    output logic [slt_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    // input register
    logic                    r_in_valid;
    logic                    r_in_has;
    logic [7:0]              r_in_byte;
    logic                    r_in_eol;

    // tokenizer state and limit
    slt_pkg::t_state         r_state;
    slt_pkg::t_state         n_state;
    logic [7:0]              r_max_tokens;

    // result register
    logic                    r_out_valid;
    slt_pkg::t_result        r_out;
    slt_pkg::t_result        n_out;

    logic                    out_advance;
    logic                    in_advance;
    logic                    cfg_wr;

    // the result register loads whenever it is empty or being drained
    assign out_advance = !r_out_valid || i_m_axis_tready;
    assign in_advance  = !r_in_valid || out_advance;

    assign o_s_axis_tready = in_advance;

    slt_step u_step (
        .i_state       (r_state),
        .i_max_tokens  (r_max_tokens),
        .i_has_byte    (r_in_has),
        .i_in_byte     (r_in_byte),
        .i_end_of_line (r_in_eol),
        .o_state       (n_state),
        .o_result      (n_out)
    );

    // apb write decode, pready is always high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == slt_pkg::REG_MAX_TOKENS);

    always_comb begin
        prdata = '0;
        if (paddr[2] == slt_pkg::REG_MAX_TOKENS) begin
            prdata = {{(slt_pkg::DATA_W-8){1'b0}}, r_max_tokens};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= slt_pkg::STATE_RST;
            r_max_tokens <= slt_pkg::MAX_TOKENS_RST;
        end else begin
            if (in_advance) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_advance) begin
                r_out_valid <= r_in_valid;
                // state only moves with the transaction it belongs to
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
            if (cfg_wr) begin
                r_max_tokens <= pwdata[7:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_advance) begin
            r_in_has  <= i_s_axis_tuser[0];
            r_in_byte <= i_s_axis_tdata[7:0];
            r_in_eol  <= i_s_axis_tlast;
        end
        if (out_advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out.line_end;
    assign o_m_axis_tuser  = {r_out.token_end, r_out.char_valid};
    assign o_m_axis_tdata  = {6'd0, r_out.token_total, r_out.line_status, r_out.out_char};

endmodule

`default_nettype wire

// File: design/slt_checker.sv
// ----------------------------------------------------------------------------
// slt_checker
// port-level checks of the shell line tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

module slt_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    input  wire logic [slt_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    input  wire logic [slt_pkg::M_TUSER_W-1:0]  o_m_axis_tuser,
    input  wire logic                           o_m_axis_tlast
);

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // status only reported at line end
    a_status_at_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tdata[9:8] == 2'd0)
        else $error("line status outside line end");

    // a failing line end carries no character and no token end
    a_error_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast && o_m_axis_tdata[9:8] != 2'd0 |->
            o_m_axis_tuser == '0)
        else $error("character or token end on failed line");

    // character is zero unless marked valid
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[7:0] == 8'd0)
        else $error("stray character");

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

// File: sim/tb_shell_line_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_line_tokenizer
// self-checking bench for the shell line tokenizer: a directed table, then
// random command lines under several token limits, every output transaction
// compared field by field against a typed value or the behavioral tokenizer in the bench
// ----------------------------------------------------------------------------

module tb_shell_line_tokenizer;

    import slt_pkg::*;

    localparam int RESET_CYCLES    = 6;
    localparam int ITEMS           = 1450;
    localparam int PHASES          = 8;
    localparam int LONG_LINE_TOKS  = 257;              // two past the widest limit
    localparam int LONG_LINE_ITEMS = 2 * LONG_LINE_TOKS;
    localparam int PHASE_ITEMS     = (ITEMS - LONG_LINE_ITEMS) / (PHASES - 1);
    localparam int HOLD_CYCLES     = 300;              // long receiver hold-off
    localparam int DRAIN_CYCLES    = 4;                // two-stage pipe plus margin
    localparam int STALL_LIMIT     = 4000;             // cycles with no transaction

    typedef enum logic {
        RK_ITEM,
        RK_CFG
    } t_row_kind;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        t_row_kind   kind;
        logic        has;
        logic [7:0]  data;
        logic        eol;
        logic        typed;
        t_result     want;
    } t_dir_row;

    localparam t_result NO_WANT = '0;

    localparam logic [7:0] SPECIALS [5] = '{CH_SPACE, CH_TAB, CH_DQUOTE, CH_SQUOTE,
                                            CH_BSLASH};

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic [S_TUSER_W-1:0]    s_tuser = '0;
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [M_TUSER_W-1:0]    m_tuser;
    logic                    m_tlast;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    shell_line_tokenizer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_axis_tvalid  (s_tvalid),
        .o_s_axis_tready  (s_tready),
        .i_s_axis_tdata   (s_tdata),    // [7:0] in_byte
        .i_s_axis_tuser   (s_tuser),    // [0] has_byte
        .i_s_axis_tlast   (s_tlast),    // end_of_line
        .o_m_axis_tvalid  (m_tvalid),
        .i_m_axis_tready  (m_tready),
        .o_m_axis_tdata   (m_tdata),    // [7:0] out_char, [9:8] status, [17:10] total
        .o_m_axis_tuser   (m_tuser),    // [0] char_valid, [1] token_end
        .o_m_axis_tlast   (m_tlast),    // line_end
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // ------------------------------------------------------------------------
    // behavioral tokenizer: its own copy of the per-line state and the limit
    // ------------------------------------------------------------------------
    t_quote      q_mode;
    logic        esc_pend;
    logic        in_tok;
    logic [7:0]  tok_cnt;
    t_status     err_lat;
    logic [7:0]  tok_limit;

    t_result     pending_results [$];   // expected output transactions, oldest first
    logic [7:0]  line_bytes [$];        // command line under construction
    int unsigned items_sent = 0;        // transactions carrying a byte or an end of line
    int unsigned fails = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;

    function automatic void clear_line();
        q_mode   = QM_NONE;
        esc_pend = 1'b0;
        in_tok   = 1'b0;
        tok_cnt  = 8'd0;
        err_lat  = ST_OK;
    endfunction

    // a completed token either counts or trips the limit
    function automatic logic close_token();
        in_tok = 1'b0;
        if (tok_cnt >= tok_limit) begin
            err_lat = ST_TOOMANY;
            return 1'b0;
        end
        tok_cnt = tok_cnt + 8'd1;
        return 1'b1;
    endfunction

    function automatic t_result tokenize_step(input logic has, input logic [7:0] b,
                                              input logic eol);
        t_result r;
        t_status err_before;
        r = '0;
        err_before = err_lat;

        if (has && err_lat == ST_OK) begin
            case (q_mode)
                QM_DOUBLE: begin
                    if (esc_pend) begin
                        esc_pend = 1'b0;
                        r.char_valid = 1'b1;
                        r.out_char = b;
                    end else if (b == CH_DQUOTE) begin
                        q_mode = QM_NONE;
                    end else if (b == CH_BSLASH) begin
                        esc_pend = 1'b1;
                    end else begin
                        r.char_valid = 1'b1;
                        r.out_char = b;
                    end
                end
                QM_SINGLE: begin
                    if (b == CH_SQUOTE) begin
                        q_mode = QM_NONE;
                    end else begin
                        r.char_valid = 1'b1;
                        r.out_char = b;
                    end
                end
                default: begin
                    if (esc_pend) begin
                        esc_pend = 1'b0;
                        r.char_valid = 1'b1;
                        r.out_char = b;
                    end else if (b == CH_SPACE || b == CH_TAB) begin
                        if (in_tok)
                            r.token_end = close_token();
                    end else if (b == CH_DQUOTE) begin
                        q_mode = QM_DOUBLE;
                        in_tok = 1'b1;
                    end else if (b == CH_SQUOTE) begin
                        q_mode = QM_SINGLE;
                        in_tok = 1'b1;
                    end else if (b == CH_BSLASH) begin
                        esc_pend = 1'b1;
                        in_tok = 1'b1;
                    end else begin
                        r.char_valid = 1'b1;
                        r.out_char = b;
                        in_tok = 1'b1;
                    end
                end
            endcase
        end

        if (eol && err_lat == ST_OK) begin
            if (esc_pend && q_mode == QM_DOUBLE) begin
                err_lat = ST_UNTERM;
            end else if (esc_pend) begin
                // dangling backslash outside quotes is kept literally
                esc_pend = 1'b0;
                r.char_valid = 1'b1;
                r.out_char = CH_BSLASH;
                r.token_end = r.token_end | close_token();
            end else if (q_mode != QM_NONE) begin
                err_lat = ST_UNTERM;
            end else if (in_tok) begin
                r.token_end = r.token_end | close_token();
            end
        end

        // error transaction and everything after it carry no token output
        if (err_before != ST_OK || err_lat != ST_OK) begin
            r.char_valid = 1'b0;
            r.out_char = 8'd0;
            r.token_end = 1'b0;
        end

        r.token_total = tok_cnt;
        if (eol) begin
            r.line_end = 1'b1;
            r.line_status = err_lat;
            clear_line();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    // offers one transaction, predicts it once accepted; tvalid stays high
    // into the next call unless a gap is drawn
    task automatic send_item(input logic has, input logic [7:0] data, input logic eol,
                             input logic typed, input t_result want);
        t_result predicted;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has;
        s_tlast  <= eol;
        do @(posedge i_clk); while (!s_tready);
        predicted = tokenize_step(has, data, eol);
        pending_results.push_back(typed ? want : predicted);
        if (has || eol)
            items_sent++;
    endtask

    // stop offering and wait for every expected transaction to come out
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write of max_tokens; upper data bits are random and must be ignored
    task automatic cfg_write(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * REG_MAX_TOKENS);
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tok_limit = value;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_SPACE || b == CH_TAB || b == CH_DQUOTE || b == CH_SQUOTE ||
               b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] sep_byte();
        return $urandom_range(0, 1) ? CH_TAB : CH_SPACE;
    endfunction

    // mostly well-formed lines of words built from plain runs, escapes and
    // quoted pieces; the rest is noise or a line with its last byte cut off
    function automatic void build_line();
        int unsigned nwords;
        logic [7:0]  b;
        line_bytes.delete();
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 12))
                line_bytes.push_back($urandom_range(0, 1) ? SPECIALS[$urandom_range(0, 4)]
                                                          : 8'($urandom_range(0, 255)));
            return;
        end
        // now and then aim at the token limit
        if ($urandom_range(0, 7) == 0)
            nwords = (tok_limit > 28) ? 30 : int'(tok_limit) + $urandom_range(0, 2);
        else
            nwords = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            line_bytes.push_back(sep_byte());
        for (int w = 0; w < nwords; w++) begin
            if (w != 0)
                repeat ($urandom_range(1, 2)) line_bytes.push_back(sep_byte());
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 4))
                    1: begin
                        line_bytes.push_back(CH_BSLASH);
                        line_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    2: begin
                        line_bytes.push_back(CH_DQUOTE);
                        repeat ($urandom_range(0, 4)) begin
                            if ($urandom_range(0, 3) == 0) begin
                                line_bytes.push_back(CH_BSLASH);
                                line_bytes.push_back(8'($urandom_range(0, 255)));
                            end else begin
                                line_bytes.push_back($urandom_range(0, 2) == 0 ? sep_byte()
                                                                               : plain_byte());
                            end
                        end
                        line_bytes.push_back(CH_DQUOTE);
                    end
                    3: begin
                        line_bytes.push_back(CH_SQUOTE);
                        repeat ($urandom_range(0, 4)) begin
                            b = 8'($urandom_range(0, 255));
                            line_bytes.push_back(b == CH_SQUOTE ? plain_byte() : b);
                        end
                        line_bytes.push_back(CH_SQUOTE);
                    end
                    default: begin
                        repeat ($urandom_range(1, 4)) line_bytes.push_back(plain_byte());
                    end
                endcase
            end
        end
        if ($urandom_range(0, 3) == 0)
            line_bytes.push_back(sep_byte());
        // broken line: lose the last byte, such as a closing quote or an escaped byte
        if ($urandom_range(0, 9) == 0 && line_bytes.size() != 0)
            void'(line_bytes.pop_back());
    endfunction

    // end of line rides on the last byte or on an empty transaction;
    // empty idle transactions are sprinkled in between
    task automatic send_line();
        bit eol_on_last;
        eol_on_last = $urandom_range(0, 1);
        if (line_bytes.size() == 0)
            eol_on_last = 1'b0;
        foreach (line_bytes[i]) begin
            if ($urandom_range(0, 19) == 0)
                send_item(1'b0, 8'($urandom), 1'b0, 1'b0, NO_WANT);
            send_item(1'b1, line_bytes[i], eol_on_last && i == line_bytes.size() - 1,
                      1'b0, NO_WANT);
        end
        if (!eol_on_last)
            send_item(1'b0, 8'($urandom), 1'b1, 1'b0, NO_WANT);
    endtask

    // ------------------------------------------------------------------------
    // receiver side: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker: each output transaction against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.char_valid  = m_tuser[0];
            got.out_char    = m_tdata[7:0];
            got.token_end   = m_tuser[1];
            got.line_end    = m_tlast;
            got.line_status = t_status'(m_tdata[9:8]);
            got.token_total = m_tdata[17:10];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b tlast=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                fails++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[23:18] !== 6'd0) begin
                    $display("%0t: mismatch expected cv=%b ch=%h te=%b le=%b st=%0d tot=%0d",
                             $time, want.char_valid, want.out_char, want.token_end,
                             want.line_end, want.line_status, want.token_total);
                    $display("%0t:          actual   cv=%b ch=%h te=%b le=%b st=%0d tot=%0d pad=%h",
                             $time, got.char_valid, got.out_char, got.token_end,
                             got.line_end, got.line_status, got.token_total, m_tdata[23:18]);
                    fails++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transaction on any port ends the run
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("tb_shell_line_tokenizer NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // directed table: expected values typed in where obvious
    // ------------------------------------------------------------------------
    localparam int DIR_ROWS = 31;

    t_dir_row dir_rows [DIR_ROWS] = '{
        // plain token then a space, default limit
        '{RK_ITEM, 1'b1, "a",       1'b0, 1'b1, '{1'b1, "a",   1'b0, 1'b0, ST_OK, 8'd0}},
        '{RK_ITEM, 1'b1, CH_SPACE,  1'b0, 1'b1, '{1'b0, 8'd0,  1'b1, 1'b0, ST_OK, 8'd1}},
        // idle transaction, data bits ignored
        '{RK_ITEM, 1'b0, 8'hA5,     1'b0, 1'b0, NO_WANT},
        // double quotes: space kept, escaped quote, close
        '{RK_ITEM, 1'b1, CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_SPACE,  1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_BSLASH, 1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
        // single quotes: backslash and double quote are literal
        '{RK_ITEM, 1'b1, CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_BSLASH, 1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_TAB,    1'b0, 1'b0, NO_WANT},
        // empty quoted pair still a token, closed by an empty end of line
        '{RK_ITEM, 1'b1, CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b0, 8'h00,     1'b1, 1'b0, NO_WANT},
        // trailing backslash outside quotes becomes a literal backslash
        '{RK_ITEM, 1'b1, CH_BSLASH, 1'b1, 1'b1, '{1'b1, CH_BSLASH, 1'b1, 1'b1, ST_OK, 8'd1}},
        // trailing backslash inside double quotes
        '{RK_ITEM, 1'b1, CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_BSLASH, 1'b1, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b1, ST_UNTERM, 8'd0}},
        // single quote left open
        '{RK_ITEM, 1'b1, CH_SQUOTE, 1'b1, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b1, ST_UNTERM, 8'd0}},
        // byte extremes, zero is an ordinary character
        '{RK_ITEM, 1'b1, 8'hFF,     1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0, ST_OK, 8'd0}},
        '{RK_ITEM, 1'b1, 8'h00,     1'b1, 1'b1, '{1'b1, 8'h00, 1'b1, 1'b1, ST_OK, 8'd1}},
        // limit of one: second token trips it, the rest of the line is dropped
        '{RK_CFG,  1'b0, 8'd1,      1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, "a",       1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_SPACE,  1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, "b",       1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_SPACE,  1'b0, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b0, ST_OK, 8'd1}},
        '{RK_ITEM, 1'b1, "c",       1'b1, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b1, ST_TOOMANY, 8'd1}},
        // limit of zero: even an empty quoted token is too many
        '{RK_CFG,  1'b0, 8'd0,      1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
        '{RK_ITEM, 1'b1, CH_DQUOTE, 1'b1, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b1, ST_TOOMANY, 8'd0}}
    };

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned target;
        logic [7:0]  lim;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tok_limit = MAX_TOKENS_RST;
        clear_line();
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == RK_CFG) begin
                settle();
                cfg_write(dir_rows[i].data);
            end else begin
                send_item(dir_rows[i].has, dir_rows[i].data, dir_rows[i].eol,
                          dir_rows[i].typed, dir_rows[i].want);
            end
        end
        settle();

        // random phases, one token limit each; the pipe is drained between them
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       lim = 8'd16;
                1:       lim = 8'd0;
                2:       lim = 8'd1;
                3:       lim = 8'd3;
                4:       lim = 8'($urandom_range(2, 20));
                5:       lim = 8'($urandom_range(0, 255));
                6:       lim = 8'd255;
                default: lim = 8'd16;
            endcase
            cfg_write(lim);
            // receiver holds off while the sender keeps offering
            if (phase == 1)
                hold_req = 1'b1;
            // tail of the run without idling
            if (phase == PHASES - 1)
                idle_on = 1'b0;
            target = items_sent + PHASE_ITEMS;
            if (phase == 6) begin
                // enough single-letter tokens to run past the widest limit
                line_bytes.delete();
                repeat (LONG_LINE_TOKS) begin
                    line_bytes.push_back("k");
                    line_bytes.push_back(sep_byte());
                end
                send_line();
                target = items_sent;
            end
            do begin
                build_line();
                send_line();
            end while (items_sent < target);
            settle();
        end

        if (fails == 0 && pending_results.size() == 0)
            $display("tb_shell_line_tokenizer OK");
        else
            $display("tb_shell_line_tokenizer NOT OK");
        $finish;
    end

endmodule

// File: shell_line_tokenizer.f
design/slt_pkg.sv
design/slt_step.sv
design/shell_line_tokenizer.sv
design/slt_checker.sv
sim/tb_shell_line_tokenizer.sv
